/* hw/rtl/eht_pkg.sv */
// Shared types and constants of the earliest-hits tracker.
// Depends on nothing; every other file of the block imports it.
package eht_pkg;

	localparam int RANKS_DEF   = 10;
	localparam int TIME_W      = 20;
	localparam int IDX_W       = 16;
	localparam int RANK_W      = 4;
	localparam int CNT_W       = 32;
	localparam int RANKS_CFG_W = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 20;
	localparam int QUEUE_DEPTH = 4;

	// command codes
	localparam logic CMD_HIT = 1'b0;
	localparam logic CMD_EOE = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANKS      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 1'd1;

	localparam logic [RANKS_CFG_W-1:0] RANKS_RST      = 4'd10;
	localparam logic [TIME_W-1:0]      TIME_LIMIT_RST = 20'd1000000;

	typedef struct packed {
		logic [RANKS_CFG_W-1:0] ranks_in_use;
		logic [TIME_W-1:0]      time_limit;
	} eht_cfg_t;

	// work for the rank row: insert a detected hit, or report and clear
	typedef struct packed {
		logic              flush;
		logic [TIME_W-1:0] hit_time;
		logic [IDX_W-1:0]  hit_index;
		logic              is_cherenkov;
	} eht_op_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              rank_filled;
		logic [IDX_W-1:0]  rank_hit_index;
		logic [TIME_W-1:0] rank_time;
		logic              rank_is_cherenkov;
		logic [CNT_W-1:0]  cherenkov_total;
		logic [CNT_W-1:0]  events_seen;
		logic              last;
	} eht_result_t;

endpackage

/* hw/rtl/eht_ifs.sv */
// Valid/ready channel interfaces for hit words and rank result words.
// Depends on eht_pkg.
interface eht_hit_if import eht_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [TIME_W-1:0] hit_time;
	logic              is_detected;
	logic              is_cherenkov;
	logic [IDX_W-1:0]  hit_index;

	modport source (output valid, cmd, hit_time, is_detected, is_cherenkov, hit_index,
		input ready);
	modport sink (input valid, cmd, hit_time, is_detected, is_cherenkov, hit_index,
		output ready);
endinterface

interface eht_rank_if import eht_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank;
	logic              rank_filled;
	logic [IDX_W-1:0]  rank_hit_index;
	logic [TIME_W-1:0] rank_time;
	logic              rank_is_cherenkov;
	logic [CNT_W-1:0]  cherenkov_total;
	logic [CNT_W-1:0]  events_seen;
	logic              last;

	modport source (output valid, rank, rank_filled, rank_hit_index, rank_time,
		rank_is_cherenkov, cherenkov_total, events_seen, last, input ready);
	modport sink (input valid, rank, rank_filled, rank_hit_index, rank_time,
		rank_is_cherenkov, cherenkov_total, events_seen, last, output ready);
endinterface

/* hw/rtl/earliest_hits_top_n_tracker_core.sv */
// Earliest-hits tracker: hit words in, N rank words out per end of event.
// A hit passes the input-stage register and the op queue before the rank row takes
// it; rank words leave through the output register, one per cycle unless stalled.
// Throughput: one hit per cycle while the queue has room; an end of event holds
// the rank row while the report sequencer shifts out its N ranks (N = ranks in use).
// Reset: ranks, counters and queue clear at once; registers return to 10 / 1000000.
module earliest_hits_top_n_tracker_core import eht_pkg::*; #(
	parameter int RANKS = RANKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	eht_hit_if.sink               hits,
	eht_rank_if.source            results,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	eht_cfg_t cfg_q;
	logic     push_valid;
	logic     push_ready;
	eht_op_t  push_op;
	logic     pop_valid;
	logic     pop;
	eht_op_t  pop_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ranks_in_use <= RANKS_RST;
			cfg_q.time_limit   <= TIME_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RANKS:      cfg_q.ranks_in_use <= cfg_data[RANKS_CFG_W-1:0];
				REG_TIME_LIMIT: cfg_q.time_limit   <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	eht_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hits       (hits),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready)
	);

	eht_op_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_op     (pop_op)
	);

	eht_rank_row #(.RANKS(RANKS)) u_rank_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.op_valid (pop_valid),
		.op       (pop_op),
		.op_pop   (pop),
		.results  (results)
	);

endmodule

/* hw/rtl/eht_front.sv */
// Input stage: accepts hit words, drops undetected hits, turns the rest into ops.
// Depends on eht_pkg and eht_hit_if.
module eht_front import eht_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	eht_hit_if.sink   hits,
	output logic      push_valid,
	output eht_op_t   push_op,
	input  logic      push_ready
);

	logic    vld_s1;
	eht_op_t op_s1;
	logic    accept;
	logic    keep;

	assign hits.ready = !vld_s1 || push_ready;
	assign accept     = hits.valid && hits.ready;
	assign keep       = (hits.cmd == CMD_EOE) || hits.is_detected;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= keep;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1.flush        <= (hits.cmd == CMD_EOE);
			op_s1.hit_time     <= hits.hit_time;
			op_s1.hit_index    <= hits.hit_index;
			op_s1.is_cherenkov <= hits.is_cherenkov;
		end
	end

	assign push_valid = vld_s1;
	assign push_op    = op_s1;

endmodule

/* hw/rtl/eht_op_queue.sv */
// Short FIFO of ops between the input stage and the rank row.
// Depends on eht_pkg.
module eht_op_queue import eht_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  eht_op_t push_op,
	output logic    pop_valid,
	input  logic    pop,
	output eht_op_t pop_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	eht_op_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_op     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/eht_rank_row.sv */
// Rank row: compare-and-shift insertion, end-of-event report sequencer and
// output register. Depends on eht_pkg and eht_rank_if.
module eht_rank_row import eht_pkg::*; #(
	parameter int RANKS = RANKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  eht_cfg_t   cfg,
	input  logic       op_valid,
	input  eht_op_t    op,
	output logic       op_pop,
	eht_rank_if.source results
);

	localparam int IW = (RANKS > 1) ? $clog2(RANKS) : 1;

	logic [TIME_W-1:0] s_time_q [RANKS];
	logic [IDX_W-1:0]  s_idx_q  [RANKS];
	logic              s_ch_q   [RANKS];
	logic              s_vld_q  [RANKS];
	logic [CNT_W-1:0]  cnt_q    [RANKS];
	logic [CNT_W-1:0]  ev_q;
	logic              busy_q;
	logic [IW-1:0]     k_q;
	logic [IW-1:0]     last_q;
	logic              out_vld_q;
	eht_result_t       out_q;

	logic [IW-1:0]     last_idx;
	wire  [RANKS-1:0]  beats;
	logic [RANKS-1:0]  first;
	logic [RANKS-1:0]  pre;
	logic              do_insert;
	logic              do_start;
	logic              emit;
	logic              end_emit;
	logic [CNT_W-1:0]  cnt_upd;

	// last rank in use: zero acts as one, above RANKS acts as RANKS
	always_comb begin
		if (cfg.ranks_in_use == '0) begin
			last_idx = '0;
		end else if (int'(cfg.ranks_in_use) > RANKS) begin
			last_idx = IW'(RANKS - 1);
		end else begin
			last_idx = IW'(cfg.ranks_in_use - 4'd1);
		end
	end

	assign op_pop    = op_valid && !busy_q;
	assign do_insert = op_pop && !op.flush;
	assign do_start  = op_pop && op.flush;
	assign emit      = busy_q && (!out_vld_q || results.ready);
	assign end_emit  = emit && (k_q == last_q);

	// lowest beaten rank, and every rank at or above it
	assign first = beats & (~beats + RANKS'(1));
	assign pre   = ~(first - RANKS'(1));

	// rank 0 always holds the rank being reported
	assign cnt_upd = (s_vld_q[0] && s_ch_q[0] && cnt_q[0] != '1) ? cnt_q[0] + 1'b1
		: cnt_q[0];

	for (genvar h = 0; h < RANKS; h++) begin : g_rank
		localparam logic [IW-1:0] H = IW'(h);
		logic              act;
		logic              shift_dn;
		logic [TIME_W-1:0] nx_time;
		logic [IDX_W-1:0]  nx_idx;
		logic              nx_ch;
		logic              nx_vld;
		logic [CNT_W-1:0]  nx_cnt;
		logic [TIME_W-1:0] pv_time;
		logic [IDX_W-1:0]  pv_idx;
		logic              pv_ch;
		logic              pv_vld;
		logic              pv_pre;

		assign act = (H <= last_idx);
		assign beats[h] = act && (s_vld_q[h] ? (op.hit_time < s_time_q[h])
			: (op.hit_time < cfg.time_limit));

		if (h < RANKS - 1) begin : g_nx
			assign nx_time = s_time_q[h+1];
			assign nx_idx  = s_idx_q[h+1];
			assign nx_ch   = s_ch_q[h+1];
			assign nx_vld  = s_vld_q[h+1];
			assign nx_cnt  = cnt_q[h+1];
		end else begin : g_nx_end
			assign nx_time = '0;
			assign nx_idx  = '0;
			assign nx_ch   = 1'b0;
			assign nx_vld  = 1'b0;
			assign nx_cnt  = '0;
		end

		if (h > 0) begin : g_pv
			assign pv_time = s_time_q[h-1];
			assign pv_idx  = s_idx_q[h-1];
			assign pv_ch   = s_ch_q[h-1];
			assign pv_vld  = s_vld_q[h-1];
			assign pv_pre  = pre[h-1];
		end else begin : g_pv_top
			assign pv_time = '0;
			assign pv_idx  = '0;
			assign pv_ch   = 1'b0;
			assign pv_vld  = 1'b0;
			assign pv_pre  = 1'b0;
		end

		assign shift_dn = pv_pre && act;

		// report shifts the row toward rank 0; insert shifts it away
		always_ff @(posedge clk) begin
			if (emit) begin
				s_time_q[h] <= nx_time;
				s_idx_q[h]  <= nx_idx;
				s_ch_q[h]   <= nx_ch;
			end else if (do_insert) begin
				if (first[h]) begin
					s_time_q[h] <= op.hit_time;
					s_idx_q[h]  <= op.hit_index;
					s_ch_q[h]   <= op.is_cherenkov;
				end else if (shift_dn) begin
					s_time_q[h] <= pv_time;
					s_idx_q[h]  <= pv_idx;
					s_ch_q[h]   <= pv_ch;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				s_vld_q[h] <= 1'b0;
			end else if (emit) begin
				s_vld_q[h] <= end_emit ? 1'b0 : nx_vld;
			end else if (do_insert) begin
				if (first[h]) begin
					s_vld_q[h] <= 1'b1;
				end else if (shift_dn) begin
					s_vld_q[h] <= pv_vld;
				end
			end
		end

		// rotate the counts in use so rank k sits at 0 when it is reported
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[h] <= '0;
			end else if (emit && H <= last_q) begin
				cnt_q[h] <= (H == last_q) ? cnt_upd : nx_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			k_q       <= '0;
			last_q    <= '0;
			ev_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (do_start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				last_q <= last_idx;
				if (ev_q != '1) begin
					ev_q <= ev_q + 1'b1;
				end
			end else if (emit) begin
				if (end_emit) begin
					busy_q <= 1'b0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.rank              <= RANK_W'(k_q);
			out_q.rank_filled       <= s_vld_q[0];
			out_q.rank_hit_index    <= s_vld_q[0] ? s_idx_q[0] : '0;
			out_q.rank_time         <= s_vld_q[0] ? s_time_q[0] : '0;
			out_q.rank_is_cherenkov <= s_vld_q[0] && s_ch_q[0];
			out_q.cherenkov_total   <= cnt_upd;
			out_q.events_seen       <= ev_q;
			out_q.last              <= (k_q == last_q);
		end
	end

	assign results.valid             = out_vld_q;
	assign results.rank              = out_q.rank;
	assign results.rank_filled       = out_q.rank_filled;
	assign results.rank_hit_index    = out_q.rank_hit_index;
	assign results.rank_time         = out_q.rank_time;
	assign results.rank_is_cherenkov = out_q.rank_is_cherenkov;
	assign results.cherenkov_total   = out_q.cherenkov_total;
	assign results.events_seen       = out_q.events_seen;
	assign results.last              = out_q.last;

endmodule

/* hw/rtl/eht_checker.sv */
// Port-level checks of the tracker's result channel, bound to the top level.
// Depends on eht_pkg and earliest_hits_top_n_tracker_core.
module eht_checker import eht_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [RANK_W-1:0] rank,
	input logic              rank_filled,
	input logic [IDX_W-1:0]  rank_hit_index,
	input logic [TIME_W-1:0] rank_time,
	input logic              rank_is_cherenkov,
	input logic [CNT_W-1:0]  cherenkov_total,
	input logic [CNT_W-1:0]  events_seen,
	input logic              last
);

	// hold a stalled word
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(rank) && $stable(rank_time)
			&& $stable(rank_hit_index) && $stable(cherenkov_total) && $stable(last))
		else $error("result word changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !rank_filled |-> rank_hit_index == '0 && rank_time == '0
			&& !rank_is_cherenkov)
		else $error("empty rank carries hit data");

	a_cher_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && rank_is_cherenkov |-> cherenkov_total != '0)
		else $error("Cherenkov rank with zero count");

	a_event_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> events_seen != '0)
		else $error("result word before any event counted");

endmodule

bind earliest_hits_top_n_tracker_core eht_checker u_eht_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (results.valid),
	.res_ready         (results.ready),
	.rank              (results.rank),
	.rank_filled       (results.rank_filled),
	.rank_hit_index    (results.rank_hit_index),
	.rank_time         (results.rank_time),
	.rank_is_cherenkov (results.rank_is_cherenkov),
	.cherenkov_total   (results.cherenkov_total),
	.events_seen       (results.events_seen),
	.last              (results.last)
);

/* verif/earliest_hits_top_n_tracker_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the earliest-hits tracker core: sends hit and end-of-event
// words, predicts the rank words of every event and checks them in arrival order.
// Depends on eht_pkg, the channel interfaces in eht_ifs.sv and the tracker core.
module earliest_hits_top_n_tracker_core_tb;
	import eht_pkg::*;

	localparam int NR       = RANKS_DEF;
	localparam int IDLE_PCT = 21;
	localparam int SETTLE   = 8;
	localparam int RANDOM_WORDS = 200;

	typedef struct packed {
		logic              cmd;
		logic [TIME_W-1:0] hit_time;
		logic              is_detected;
		logic              is_cherenkov;
		logic [IDX_W-1:0]  hit_index;
	} hit_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	eht_hit_if  hits ();
	eht_rank_if results ();

	earliest_hits_top_n_tracker_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.hits      (hits),
		.results   (results),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// shadow of the rank row, the counters and the registers
	logic [TIME_W-1:0]      held_time [NR];
	logic [IDX_W-1:0]       held_index [NR];
	logic                   held_cherenkov [NR];
	logic                   held_valid [NR];
	logic [CNT_W-1:0]       cherenkov_per_rank [NR];
	logic [CNT_W-1:0]       event_total;
	logic [RANKS_CFG_W-1:0] ranks_reg;
	logic [TIME_W-1:0]      limit_reg;

	eht_result_t rank_words_due [$];
	eht_result_t due;
	int          errors = 0;
	bit          steady = 1'b0;

	function automatic int ranks_active();
		if (ranks_reg == '0)
			return 1;
		if (int'(ranks_reg) > NR)
			return NR;
		return int'(ranks_reg);
	endfunction

	function automatic void clear_row();
		for (int k = 0; k < NR; k++) begin
			held_time[k] = '0;
			held_index[k] = '0;
			held_cherenkov[k] = 1'b0;
			held_valid[k] = 1'b0;
		end
	endfunction

	function automatic void insert_hit(input hit_word_t w);
		int n;
		bit beats;
		n = ranks_active();
		for (int k = 0; k < n; k++) begin
			beats = held_valid[k] ? (w.hit_time < held_time[k]) : (w.hit_time < limit_reg);
			if (beats) begin
				// shift later ranks down, the last rank in use drops out
				for (int h = n - 1; h > k; h--) begin
					held_time[h] = held_time[h-1];
					held_index[h] = held_index[h-1];
					held_cherenkov[h] = held_cherenkov[h-1];
					held_valid[h] = held_valid[h-1];
				end
				held_time[k] = w.hit_time;
				held_index[k] = w.hit_index;
				held_cherenkov[k] = w.is_cherenkov;
				held_valid[k] = 1'b1;
				return;
			end
		end
	endfunction

	function automatic void report_event();
		eht_result_t r;
		int n;
		bit f;
		n = ranks_active();
		if (event_total != '1)
			event_total++;
		for (int k = 0; k < n; k++) begin
			f = held_valid[k];
			if (f && held_cherenkov[k] && cherenkov_per_rank[k] != '1)
				cherenkov_per_rank[k]++;
			r.rank = RANK_W'(k);
			r.rank_filled = f;
			r.rank_hit_index = f ? held_index[k] : '0;
			r.rank_time = f ? held_time[k] : '0;
			r.rank_is_cherenkov = f ? held_cherenkov[k] : 1'b0;
			r.cherenkov_total = cherenkov_per_rank[k];
			r.events_seen = event_total;
			r.last = (k == n - 1);
			rank_words_due = {rank_words_due, r};
		end
		clear_row();
	endfunction

	function automatic void track_word(input hit_word_t w);
		if (w.cmd == CMD_EOE)
			report_event();
		else if (w.is_detected)
			insert_hit(w);
	endfunction

	function automatic hit_word_t make_hit(input logic [TIME_W-1:0] t, input logic [IDX_W-1:0] idx,
		input logic det, input logic ch);
		hit_word_t w;
		w.cmd = CMD_HIT;
		w.hit_time = t;
		w.hit_index = idx;
		w.is_detected = det;
		w.is_cherenkov = ch;
		return w;
	endfunction

	// the other fields of an end-of-event word carry noise
	function automatic hit_word_t end_word();
		hit_word_t w;
		w = make_hit(TIME_W'($urandom), IDX_W'($urandom), 1'($urandom), 1'($urandom));
		w.cmd = CMD_EOE;
		return w;
	endfunction

	// mix full-range times, small times that tie often, and times around the limit
	function automatic hit_word_t random_hit();
		logic [TIME_W-1:0] t;
		case ($urandom_range(2))
			0: t = TIME_W'($urandom);
			1: t = TIME_W'($urandom_range(31));
			default: t = TIME_W'(int'(limit_reg) + int'($urandom_range(7)) - 4);
		endcase
		return make_hit(t, IDX_W'($urandom), $urandom_range(9) != 0, 1'($urandom));
	endfunction

	function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
		input logic [CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	task automatic send_word(input hit_word_t w);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			hits.valid <= 1'b0;
			@(posedge clk);
		end
		hits.valid <= 1'b1;
		hits.cmd <= w.cmd;
		hits.hit_time <= w.hit_time;
		hits.is_detected <= w.is_detected;
		hits.is_cherenkov <= w.is_cherenkov;
		hits.hit_index <= w.hit_index;
		@(posedge clk);
		while (hits.ready !== 1'b1)
			@(posedge clk);
		track_word(w);
	endtask

	// hold off until every rank word is back and the row has settled
	task automatic drain();
		hits.valid <= 1'b0;
		@(posedge clk);
		while (rank_words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_RANKS)
			ranks_reg = data[RANKS_CFG_W-1:0];
		else
			limit_reg = data[TIME_W-1:0];
	endtask

	task automatic set_ranks(input int n);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[RANKS_CFG_W-1:0] = RANKS_CFG_W'(n);
		write_reg(REG_RANKS, d);
	endtask

	task automatic set_limit(input logic [TIME_W-1:0] t);
		write_reg(REG_TIME_LIMIT, CFG_DATA_W'(t));
	endtask

	task automatic test_directed();
		// empty event: every rank comes back empty
		send_word(end_word());
		send_word(make_hit(20'd500, 16'hFFFF, 1'b1, 1'b1));
		send_word(make_hit(20'd0, 16'h0000, 1'b1, 1'b1));
		send_word(make_hit(20'd999999, 16'd3, 1'b1, 1'b0));
		send_word(make_hit(20'd1000000, 16'd4, 1'b1, 1'b1));
		send_word(make_hit(20'hFFFFF, 16'd5, 1'b1, 1'b1));
		send_word(make_hit(20'd5, 16'd6, 1'b0, 1'b1));
		// equal time lands behind the held hit
		send_word(make_hit(20'd500, 16'd7, 1'b1, 1'b0));
		send_word(end_word());
		// each hit beats all held ones, the eleventh pushes the oldest out
		for (int i = 0; i < 11; i++)
			send_word(make_hit(TIME_W'(1000 - 10 * i), IDX_W'(100 + i), 1'b1, 1'(i)));
		send_word(end_word());
		drain();
	endtask

	task automatic test_rank_settings();
		int sizes [6] = '{1, 0, 15, 11, 5, 10};
		foreach (sizes[s]) begin
			set_ranks(sizes[s]);
			repeat ($urandom_range(ranks_active() + 3)) send_word(random_hit());
			send_word(end_word());
			drain();
		end
	endtask

	task automatic test_time_limit();
		logic [TIME_W-1:0] limits [4] = '{20'd0, 20'd1, 20'hFFFFF, 20'd1000};
		foreach (limits[j]) begin
			set_limit(limits[j]);
			send_word(make_hit(20'd0, IDX_W'($urandom), 1'b1, 1'b1));
			send_word(make_hit(limits[j] - 20'd1, IDX_W'($urandom), 1'b1, 1'b0));
			send_word(make_hit(limits[j], IDX_W'($urandom), 1'b1, 1'b1));
			send_word(make_hit(20'hFFFFF, IDX_W'($urandom), 1'b1, 1'b0));
			repeat (4) send_word(random_hit());
			send_word(end_word());
			drain();
		end

		// limit lowered mid-event: held hits stay, new ones beat held times freely
		set_limit(20'd1000000);
		set_ranks(10);
		repeat (8) send_word(make_hit(TIME_W'($urandom_range(1000, 5000)), IDX_W'($urandom),
			1'b1, 1'($urandom)));
		drain();
		set_limit(20'd100);
		send_word(make_hit(20'd3000, 16'd11, 1'b1, 1'b1));
		send_word(make_hit(20'd6000, 16'd12, 1'b1, 1'b1));
		send_word(make_hit(20'd50, 16'd13, 1'b1, 1'b0));
		drain();

		// rank count shrunk mid-event: the ranks beyond it are dropped at the end
		set_ranks(3);
		send_word(make_hit(20'd2000, 16'd14, 1'b1, 1'b1));
		send_word(make_hit(20'd20, 16'd15, 1'b1, 1'b0));
		send_word(end_word());
		drain();
		set_ranks(10);
		send_word(end_word());
		drain();
	endtask

	task automatic test_random();
		hit_word_t w;
		int sent;
		int len;
		int phase;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(3))
				0: set_ranks(10);
				1: set_ranks($urandom_range(15));
				2: set_ranks(1);
				default: set_ranks($urandom_range(2, 9));
			endcase
			case ($urandom_range(3))
				0: set_limit(20'd1000000);
				1: set_limit(TIME_W'($urandom));
				2: set_limit(20'hFFFFF);
				default: set_limit(TIME_W'($urandom_range(64)));
			endcase
			// one phase runs both sides without a gap
			steady = (phase == 1);
			repeat (6) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(14);
				repeat (len) begin
					w = random_hit();
					send_word(w);
					sent++;
				end
				send_word(end_word());
				sent++;
			end
			drain();
			steady = 1'b0;
			phase++;
		end
	endtask

	// result sink: check each accepted rank word, stall at random
	always @(posedge clk) begin
		if (arst_n && results.valid === 1'b1 && results.ready === 1'b1) begin
			if (rank_words_due.size() == 0) begin
				$error("rank word with nothing due: rank %0d", results.rank);
				errors++;
			end else begin
				due = rank_words_due.pop_front();
				check_field("rank", CNT_W'(due.rank), CNT_W'(results.rank));
				check_field("rank_filled", CNT_W'(due.rank_filled), CNT_W'(results.rank_filled));
				check_field("rank_hit_index", CNT_W'(due.rank_hit_index),
					CNT_W'(results.rank_hit_index));
				check_field("rank_time", CNT_W'(due.rank_time), CNT_W'(results.rank_time));
				check_field("rank_is_cherenkov", CNT_W'(due.rank_is_cherenkov),
					CNT_W'(results.rank_is_cherenkov));
				check_field("cherenkov_total", due.cherenkov_total, results.cherenkov_total);
				check_field("events_seen", due.events_seen, results.events_seen);
				check_field("last", CNT_W'(due.last), CNT_W'(results.last));
			end
		end
		results.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	initial begin
		hits.valid = 1'b0;
		hits.cmd = CMD_HIT;
		hits.hit_time = '0;
		hits.is_detected = 1'b0;
		hits.is_cherenkov = 1'b0;
		hits.hit_index = '0;
		results.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_RANKS;
		cfg_data = '0;
		ranks_reg = RANKS_RST;
		limit_reg = TIME_LIMIT_RST;
		event_total = '0;
		for (int k = 0; k < NR; k++)
			cherenkov_per_rank[k] = '0;
		clear_row();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_rank_settings();
		test_time_limit();
		test_random();
		drain();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
